### rtl/app_pkg.sv
package app_pkg;

  // Fixed field widths of the item and result channels.
  localparam int unsigned SizeW   = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PayOutW = 11;

  // Header bytes in front of the first packet and of every later packet.
  localparam logic [ByteW-1:0] HdrFirst = 8'h4C;
  localparam logic [ByteW-1:0] HdrNext  = 8'h5C;

  // Result status codes.
  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusBadSize    = 2'd1,
    StatusNotStarted = 2'd2,
    StatusOverflow   = 2'd3
  } status_e;

  // Input item kinds.
  typedef enum logic {
    CmdStart = 1'b0,
    CmdData  = 1'b1
  } cmd_kind_e;

  // A classified input item as it waits between front and back.
  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] data_byte;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               is_header;
    logic               packet_end;
    logic               stream_end;
    status_e            status;
    logic [PayOutW-1:0] payload_size;
    logic [SizeW-1:0]   packet_count;
    logic               last;
  } result_t;

endpackage

### rtl/app_fifo.sv
module app_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/app_div.sv
module app_div #(
  parameter int unsigned DivW = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [app_pkg::SizeW-1:0] dividend_i,
  input  logic [DivW-1:0]           divisor_i,
  output logic                      done_o,
  output logic [app_pkg::SizeW-1:0] quot_o,
  output logic                      rem_zero_o
);
  import app_pkg::*;

  localparam int unsigned StepW = $clog2(SizeW + 1);

  logic [SizeW-1:0] quo_q, quo_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  div_q;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DivW:0]    trial;
  logic             fits;

  // One restoring step per cycle: bring down the next dividend bit.
  assign trial = {rem_q, quo_q[SizeW-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      step_d = StepW'(SizeW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? DivW'(trial - {1'b0, div_q}) : DivW'(trial);
      quo_d  = {quo_q[SizeW-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quot_o     = quo_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

### rtl/app_back.sv
module app_back #(
  parameter int unsigned AlignStep  = 8,
  parameter int unsigned MaxPayload = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [app_pkg::SizeW-1:0] total_size_i,
  input  app_pkg::cmd_t             cmd_i,
  input  logic                      cmd_empty_i,
  output logic                      cmd_pop_o,
  output app_pkg::result_t          res_o,
  output logic                      res_push_o,
  input  logic                      res_full_i
);
  import app_pkg::*;

  // Payload register width and the largest candidate below the maximum.
  localparam int unsigned PayW = (MaxPayload > 2) ? $clog2(MaxPayload) : 1;
  localparam int unsigned PMax = ((MaxPayload - 1) / AlignStep) * AlignStep;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StLaunch = 2'd1;
  localparam logic [1:0] StDiv    = 2'd2;
  localparam logic [1:0] StEmit   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [PayW-1:0]  chosen_q, chosen_d;
  logic [PayW-1:0]  cand_q, cand_d;
  logic [PayW-1:0]  pos_q, pos_d;
  logic [PayW-1:0]  pos_inc;
  logic [SizeW-1:0] sent_q, sent_d;
  logic [SizeW-1:0] sent_inc;
  logic [SizeW-1:0] count_q, count_d;
  logic             started_q, started_d;
  logic             first_q, first_d;
  logic             hdr_q, hdr_d;
  logic             div_start, div_done, div_rem_zero;
  logic [SizeW-1:0] div_quot;

  app_div #(
    .DivW(PayW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (total_size_i),
    .divisor_i  (cand_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_zero_o (div_rem_zero)
  );

  assign pos_inc  = pos_q + 1'b1;
  assign sent_inc = sent_q + 1'b1;

  // Sequencer: runs the candidate search for a start and emits results.
  always_comb begin
    state_d    = state_q;
    chosen_d   = chosen_q;
    cand_d     = cand_q;
    pos_d      = pos_q;
    sent_d     = sent_q;
    count_d    = count_q;
    started_d  = started_q;
    first_d    = first_q;
    hdr_d      = hdr_q;
    div_start  = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      StIdle: begin
        if (!cmd_empty_i) begin
          if (cmd_i.kind == CmdStart) begin
            pos_d     = '0;
            sent_d    = '0;
            first_d   = 1'b1;
            hdr_d     = 1'b0;
            started_d = 1'b0;
            chosen_d  = '0;
            count_d   = '0;
            cand_d    = PayW'(PMax);
            if (total_size_i == '0 || PMax == 0) begin
              state_d = StEmit;
            end else begin
              state_d = StLaunch;
            end
          end else if (!res_full_i) begin
            res_push_o = 1'b1;
            res_o.last = 1'b1;
            if (!started_q) begin
              res_o.status = StatusNotStarted;
              cmd_pop_o    = 1'b1;
            end else if (sent_q >= total_size_i) begin
              res_o.status = StatusOverflow;
              cmd_pop_o    = 1'b1;
            end else if (pos_q == '0 && !hdr_q) begin
              // Header goes out first; the data byte stays queued and follows as a later result.
              res_o.out_byte  = first_q ? HdrFirst : HdrNext;
              res_o.is_header = 1'b1;
              res_o.last      = 1'b0;
              hdr_d           = 1'b1;
            end else begin
              res_o.out_byte   = cmd_i.data_byte;
              res_o.packet_end = (pos_inc >= chosen_q);
              res_o.stream_end = (sent_inc == total_size_i);
              cmd_pop_o        = 1'b1;
              hdr_d            = 1'b0;
              sent_d           = sent_inc;
              if (pos_inc >= chosen_q) begin
                pos_d   = '0;
                first_d = 1'b0;
              end else begin
                pos_d = pos_inc;
              end
            end
          end
        end
      end
      StLaunch: begin
        div_start = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        // Candidates go from largest down, so the first that divides wins.
        if (div_done) begin
          if (div_rem_zero) begin
            chosen_d  = cand_q;
            started_d = 1'b1;
            count_d   = div_quot;
            state_d   = StEmit;
          end else if (cand_q == PayW'(AlignStep)) begin
            state_d = StEmit;
          end else begin
            cand_d  = cand_q - PayW'(AlignStep);
            state_d = StLaunch;
          end
        end
      end
      StEmit: begin
        if (!res_full_i) begin
          res_push_o         = 1'b1;
          res_o.status       = started_q ? StatusOk : StatusBadSize;
          res_o.payload_size = PayOutW'(chosen_q);
          res_o.packet_count = count_q;
          res_o.last         = 1'b1;
          cmd_pop_o          = 1'b1;
          state_d            = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      chosen_q  <= '0;
      cand_q    <= '0;
      pos_q     <= '0;
      sent_q    <= '0;
      count_q   <= '0;
      started_q <= 1'b0;
      first_q   <= 1'b1;
      hdr_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      chosen_q  <= chosen_d;
      cand_q    <= cand_d;
      pos_q     <= pos_d;
      sent_q    <= sent_d;
      count_q   <= count_d;
      started_q <= started_d;
      first_q   <= first_d;
      hdr_q     <= hdr_d;
    end
  end

endmodule

### rtl/aligned_payload_packetizer.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+----------------------------------------------
// item      | in        | push / full        | action_i, data_byte_i
// result    | out       | empty / pop        | out_byte_o, is_header_o, packet_end_o,
//           |           |                    | stream_end_o, status_o, payload_size_o,
//           |           |                    | packet_count_o, last_o
// config    | in        | cfg_we_i           | cfg_wdata_i (total size)
//
// A data byte passes the sequencer as one result; the first byte of a packet gives two,
// the header and then the byte.
// A start runs a search over at most (MAX_PAYLOAD-1)/ALIGN_STEP candidates, each tried
// in turn by a bit-serial divider.
// Reset clears the control state and both queues; no clearing pass is needed.
// A full result queue stalls the sequencer, and a busy sequencer fills the item queue.
module aligned_payload_packetizer #(
  parameter int unsigned ALIGN_STEP  = 8,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [app_pkg::SizeW-1:0]   cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [app_pkg::ByteW-1:0]   data_byte_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [app_pkg::ByteW-1:0]   out_byte_o,
  output logic                        is_header_o,
  output logic                        packet_end_o,
  output logic                        stream_end_o,
  output logic [1:0]                  status_o,
  output logic [app_pkg::PayOutW-1:0] payload_size_o,
  output logic [app_pkg::SizeW-1:0]   packet_count_o,
  output logic                        last_o
);
  import app_pkg::*;

  logic [SizeW-1:0] total_size_q;
  cmd_t             cmd_in, cmd_out;
  logic             cmd_empty, cmd_pop;
  result_t          res_in, res_out;
  logic             res_push, res_full;

  // Total size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_size_q <= '0;
    end else if (cfg_we_i) begin
      total_size_q <= cfg_wdata_i;
    end
  end

  // Front: classify the item and queue it for the sequencer.
  assign cmd_in.kind      = action_i ? CmdData : CmdStart;
  assign cmd_in.data_byte = data_byte_i;

  app_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (2)
  ) u_cmd_q (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Back: search and stream sequencer.
  app_back #(
    .AlignStep  (ALIGN_STEP),
    .MaxPayload (MAX_PAYLOAD)
  ) u_back (
    .clk_i,
    .rst_ni,
    .total_size_i (total_size_q),
    .cmd_i        (cmd_out),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .res_o        (res_in),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  // Result queue toward the consumer.
  app_fifo #(
    .Width ($bits(result_t)),
    .Depth (2)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_byte_o     = res_out.out_byte;
  assign is_header_o    = res_out.is_header;
  assign packet_end_o   = res_out.packet_end;
  assign stream_end_o   = res_out.stream_end;
  assign status_o       = res_out.status;
  assign payload_size_o = res_out.payload_size;
  assign packet_count_o = res_out.packet_count;
  assign last_o         = res_out.last;

endmodule

### tb/aligned_payload_packetizer_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels of the packetizer, predicts the
// results of every item taken and compares each result taken against the oldest one.
module aligned_payload_packetizer_checker #(
  parameter int unsigned ALIGN_STEP  = 8,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [app_pkg::SizeW-1:0]   cfg_wdata_i,
  input  logic                        push,
  input  logic                        full,
  input  logic                        action_i,
  input  logic [app_pkg::ByteW-1:0]   data_byte_i,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [app_pkg::ByteW-1:0]   out_byte_o,
  input  logic                        is_header_o,
  input  logic                        packet_end_o,
  input  logic                        stream_end_o,
  input  logic [1:0]                  status_o,
  input  logic [app_pkg::PayOutW-1:0] payload_size_o,
  input  logic [app_pkg::SizeW-1:0]   packet_count_o,
  input  logic                        last_o,
  output int unsigned                 fail_count_o,
  output int unsigned                 outstanding_o
);

  // Own copy of the size register and of the stream position.
  logic [app_pkg::SizeW-1:0]   size_reg;
  logic [app_pkg::PayOutW-1:0] pay_len;
  logic                        stream_ok;
  logic [app_pkg::PayOutW-1:0] pkt_pos;
  logic [app_pkg::SizeW-1:0]   pkt_num;
  logic [app_pkg::SizeW-1:0]   bytes_done;

  // Results still owed by the block, oldest first.
  app_pkg::result_t pending_results[$];

  task automatic expect_result(input logic [app_pkg::ByteW-1:0] b, input logic hdr,
                               input logic pend, input logic send_end,
                               input app_pkg::status_e st,
                               input logic [app_pkg::PayOutW-1:0] pay,
                               input logic [app_pkg::SizeW-1:0] cnt, input logic fin);
    app_pkg::result_t r;
    r.out_byte     = b;
    r.is_header    = hdr;
    r.packet_end   = pend;
    r.stream_end   = send_end;
    r.status       = st;
    r.payload_size = pay;
    r.packet_count = cnt;
    r.last         = fin;
    pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [app_pkg::SizeW-1:0] want,
                             input logic [app_pkg::SizeW-1:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Results are compared before new expectations join, so a result that shows up
  // with nothing owed is never matched against the item taken at the same edge.
  always @(posedge clk_i) begin
    app_pkg::result_t want;
    int unsigned      best;
    int unsigned      cand;
    logic             pend;
    if (!rst_ni) begin
      size_reg   = '0;
      pay_len    = '0;
      stream_ok  = 1'b0;
      pkt_pos    = '0;
      pkt_num    = '0;
      bytes_done = '0;
      pending_results.delete();
      fail_count_o = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        size_reg = cfg_wdata_i;
      end

      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with nothing expected, out_byte 0x%0h, status %0d",
                   $time, out_byte_o, status_o);
        end else begin
          want = pending_results.pop_front();
          check_field("out_byte", app_pkg::SizeW'(want.out_byte),
                      app_pkg::SizeW'(out_byte_o));
          check_field("is_header", app_pkg::SizeW'(want.is_header),
                      app_pkg::SizeW'(is_header_o));
          check_field("packet_end", app_pkg::SizeW'(want.packet_end),
                      app_pkg::SizeW'(packet_end_o));
          check_field("stream_end", app_pkg::SizeW'(want.stream_end),
                      app_pkg::SizeW'(stream_end_o));
          check_field("status", app_pkg::SizeW'(want.status), app_pkg::SizeW'(status_o));
          check_field("payload_size", app_pkg::SizeW'(want.payload_size),
                      app_pkg::SizeW'(payload_size_o));
          check_field("packet_count", want.packet_count, packet_count_o);
          check_field("last", app_pkg::SizeW'(want.last), app_pkg::SizeW'(last_o));
        end
      end

      if (push && !full) begin
        if (app_pkg::cmd_kind_e'(action_i) == app_pkg::CmdStart) begin
          // A start picks the largest aligned payload that divides the size.
          best       = 0;
          pkt_pos    = '0;
          pkt_num    = '0;
          bytes_done = '0;
          if (size_reg != 0) begin
            for (cand = ALIGN_STEP; cand < MAX_PAYLOAD; cand += ALIGN_STEP) begin
              if (size_reg % cand == 0) begin
                best = cand;
              end
            end
          end
          if (best == 0) begin
            pay_len   = '0;
            stream_ok = 1'b0;
            expect_result('0, 1'b0, 1'b0, 1'b0, app_pkg::StatusBadSize, '0, '0, 1'b1);
          end else begin
            pay_len   = app_pkg::PayOutW'(best);
            stream_ok = 1'b1;
            expect_result('0, 1'b0, 1'b0, 1'b0, app_pkg::StatusOk, pay_len,
                          app_pkg::SizeW'(size_reg / best), 1'b1);
          end
        end else if (!stream_ok) begin
          expect_result('0, 1'b0, 1'b0, 1'b0, app_pkg::StatusNotStarted, '0, '0, 1'b1);
        end else if (bytes_done >= size_reg) begin
          expect_result('0, 1'b0, 1'b0, 1'b0, app_pkg::StatusOverflow, '0, '0, 1'b1);
        end else begin
          // A packet opens with its header, then the byte itself follows.
          if (pkt_pos == 0) begin
            expect_result((pkt_num == 0) ? app_pkg::HdrFirst : app_pkg::HdrNext, 1'b1,
                          1'b0, 1'b0, app_pkg::StatusOk, '0, '0, 1'b0);
          end
          pkt_pos = pkt_pos + 1'b1;
          pend    = 1'b0;
          if (pkt_pos >= pay_len) begin
            pend    = 1'b1;
            pkt_pos = '0;
            pkt_num = pkt_num + 1'b1;
          end
          bytes_done = bytes_done + 1'b1;
          expect_result(data_byte_i, 1'b0, pend, bytes_done == size_reg, app_pkg::StatusOk,
                        '0, '0, 1'b1);
        end
      end

      outstanding_o <= pending_results.size();
    end
  end

endmodule

### tb/tb_aligned_payload_packetizer.sv
`timescale 1ns / 1ps

module tb_aligned_payload_packetizer;

  localparam int unsigned AlignStep   = 8;
  localparam int unsigned MaxPayload  = 1024;
  localparam int unsigned ItemTarget  = 1380;
  localparam int unsigned SqueezeAt   = 600;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned DrainCycles = 60;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [app_pkg::SizeW-1:0]   cfg_wdata_i;
  logic                        push;
  logic                        full;
  logic                        action_i;
  logic [app_pkg::ByteW-1:0]   data_byte_i;
  logic                        empty;
  logic                        pop;
  logic [app_pkg::ByteW-1:0]   out_byte_o;
  logic                        is_header_o;
  logic                        packet_end_o;
  logic                        stream_end_o;
  logic [1:0]                  status_o;
  logic [app_pkg::PayOutW-1:0] payload_size_o;
  logic [app_pkg::SizeW-1:0]   packet_count_o;
  logic                        last_o;

  int unsigned fail_count;
  int unsigned outstanding;

  // Stimulus bookkeeping.
  int unsigned sent_items;
  int unsigned fed;
  bit          steady;
  bit          squeeze;
  bit          squeezed;

  aligned_payload_packetizer #(
    .ALIGN_STEP (AlignStep),
    .MAX_PAYLOAD(MaxPayload)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .is_header_o   (is_header_o),
    .packet_end_o  (packet_end_o),
    .stream_end_o  (stream_end_o),
    .status_o      (status_o),
    .payload_size_o(payload_size_o),
    .packet_count_o(packet_count_o),
    .last_o        (last_o)
  );

  aligned_payload_packetizer_checker #(
    .ALIGN_STEP (AlignStep),
    .MAX_PAYLOAD(MaxPayload)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .is_header_o   (is_header_o),
    .packet_end_o  (packet_end_o),
    .stream_end_o  (stream_end_o),
    .status_o      (status_o),
    .payload_size_o(payload_size_o),
    .packet_count_o(packet_count_o),
    .last_o        (last_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(16, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  // Sizes that give single packets, many small packets, huge streams or no valid payload.
  function automatic logic [app_pkg::SizeW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return app_pkg::SizeW'($urandom_range(0, 7));
      1, 2, 3: return app_pkg::SizeW'(8 * $urandom_range(1, 10));
      4, 5:    return app_pkg::SizeW'(8 * $urandom_range(1, 3) * (131 + 2 * $urandom_range(0, 10)));
      6:       return app_pkg::SizeW'($urandom);
      7:       return ($urandom_range(0, 1) != 0) ? 24'hFFFFF8 : 24'hFFFFFF;
      8:       return app_pkg::SizeW'(8 * $urandom_range(128, 512));
      default: return app_pkg::SizeW'($urandom_range(9, 200));
    endcase
  endfunction

  // Offers one item and returns once it is taken; push stays high for a following item.
  task automatic offer_item(input app_pkg::cmd_kind_e kind, input logic [app_pkg::ByteW-1:0] b);
    if (!steady && $urandom_range(0, 3) == 0) begin
      push        <= 1'b0;
      action_i    <= 1'($urandom_range(0, 1));
      data_byte_i <= app_pkg::ByteW'($urandom);
      repeat (gap_len()) @(posedge clk_i);
    end
    push        <= 1'b1;
    action_i    <= kind;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
    sent_items++;
  endtask

  task automatic start_stream();
    offer_item(app_pkg::CmdStart, app_pkg::ByteW'($urandom));
    fed = 0;
  endtask

  task automatic feed(input int unsigned n);
    repeat (n) begin
      offer_item(app_pkg::CmdData, app_pkg::ByteW'($urandom));
      fed++;
    end
  endtask

  // Drop push and wait until every owed result has been taken.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_size(input logic [app_pkg::SizeW-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stalls, bursts of steady popping, and one long hold-off.
  initial begin
    int unsigned roll;
    pop <= 1'b0;
    squeezed = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
          pop <= 1'b0;
          repeat (gap_len()) @(posedge clk_i);
        end else if (roll < 25) begin
          pop <= 1'b1;
          repeat ($urandom_range(20, 120)) @(posedge clk_i);
        end else begin
          pop <= 1'b1;
          @(posedge clk_i);
        end
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [app_pkg::SizeW-1:0] size;
    int unsigned               kind;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    action_i    <= 1'b0;
    data_byte_i <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    sent_items = 0;
    fed        = 0;
    steady     = 1'b0;
    squeeze    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Data before any start, then a start with a zero size.
    write_size('0);
    offer_item(app_pkg::CmdData, 8'hFF);
    offer_item(app_pkg::CmdStart, 8'h00);
    offer_item(app_pkg::CmdData, 8'h00);
    // The largest size is odd, so no aligned payload divides it.
    write_size(24'hFFFFFF);
    offer_item(app_pkg::CmdStart, 8'hFF);
    // The largest aligned size picks a payload just under the maximum.
    write_size(24'hFFFFF8);
    start_stream();
    offer_item(app_pkg::CmdData, 8'h00);
    offer_item(app_pkg::CmdData, 8'hFF);
    // One full packet that is also the stream end, then one byte beyond the size.
    // This start also abandons the stream under way.
    write_size(24'd8);
    start_stream();
    feed(9);
    // Payload of eight, so the second packet opens with the later header.
    write_size(24'd1048);
    start_stream();
    feed(10);

    while (sent_items < ItemTarget) begin
      steady = ($urandom_range(0, 4) == 0);
      if (!squeeze && sent_items >= SqueezeAt) begin
        // Back-to-back data while the result side holds off, so the block fills up.
        write_size(24'd1208);
        start_stream();
        push <= 1'b0;
        squeeze = 1'b1;
        while (!squeezed) @(posedge clk_i);
        steady = 1'b1;
        feed(200);
      end else begin
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
          // Fresh stream; small sizes usually run to the end and a little past it.
          size = pick_size();
          write_size(size);
          start_stream();
          if (size <= 96 && $urandom_range(0, 4) != 0) begin
            feed(size + $urandom_range(0, 3));
          end else begin
            feed($urandom_range(1, 60));
          end
        end else if (kind < 15) begin
          // Size changed under a running stream, near the bytes already sent.
          write_size(app_pkg::SizeW'(fed + $urandom_range(0, 12)));
          feed($urandom_range(1, 16));
        end else if (kind < 17) begin
          start_stream();
          feed($urandom_range(1, 40));
        end else begin
          repeat ($urandom_range(5, 30)) begin
            offer_item(($urandom_range(0, 15) == 0) ? app_pkg::CmdStart : app_pkg::CmdData,
                       app_pkg::ByteW'($urandom));
          end
        end
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/app_pkg.sv
rtl/app_fifo.sv
rtl/app_div.sv
rtl/app_back.sv
rtl/aligned_payload_packetizer.sv
tb/aligned_payload_packetizer_checker.sv
tb/tb_aligned_payload_packetizer.sv
